>>> design/dllc_pkg.sv
package dllc_pkg;

  localparam int CAPACITY = 16;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int IDX_W    = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;
  localparam int CMD_W    = 5;
  localparam int COUNT_W  = 5;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 40;

  localparam logic [IDX_W-1:0] NIL = IDX_W'(CAPACITY);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR      = 5'd0,
    CMD_INS_FIRST  = 5'd1,
    CMD_INS_LAST   = 5'd2,
    CMD_FIRST      = 5'd3,
    CMD_LAST       = 5'd4,
    CMD_GET_FIRST  = 5'd5,
    CMD_GET_LAST   = 5'd6,
    CMD_DEL_FIRST  = 5'd7,
    CMD_DEL_LAST   = 5'd8,
    CMD_DEL_AFTER  = 5'd9,
    CMD_DEL_BEFORE = 5'd10,
    CMD_INS_AFTER  = 5'd11,
    CMD_INS_BEFORE = 5'd12,
    CMD_GET        = 5'd13,
    CMD_SET        = 5'd14,
    CMD_NEXT       = 5'd15,
    CMD_PREV       = 5'd16
  } cmd_t;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    idx_t               data;
  } link_wr_t;

endpackage

>>> design/doubly_linked_list_with_cursor_top.sv
// doubly linked list of signed 32-bit values with a cursor, kept in a pool of
// CAPACITY nodes (value, next link, prev link) and a free bitmap.
// s_* channel: one command item per handshake. s_tdata bits, lowest first:
//   command[4:0], value_in[36:5], zero fill [39:37].
// m_* channel: exactly one result item per command. m_tdata bits, lowest first:
//   read_value[31:0], read_valid[32], error[33], cursor_active[34],
//   entry_count_out[39:35].
// each command is decoded, applied to the pool and its result captured in the
// output register in the cycle it is accepted, so the result shows in the cycle
// after acceptance and a new command can be taken every cycle while the receiver
// keeps up. the decode path runs through one pass of the link lookups (at most two
// chained reads) and the lowest-free-node search.
// when the receiver stalls, the result holds in the output register and
// s_tready drops until it is taken; nothing is lost or repeated.
// reset (rst, synchronous) empties the list: head, tail and cursor null, every
// node free, count zero, no result pending. node contents stay undefined
// until written and are never read before that.
module doubly_linked_list_with_cursor_top
  import dllc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // command, value_in
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // read_value, read_valid, error, cursor_active,
                                      // entry_count_out
);

  logic [VALUE_W-1:0]  value_store [CAPACITY];
  idx_t                next_link   [CAPACITY];
  idx_t                prev_link   [CAPACITY];

  idx_t                head_index, head_index_next;
  idx_t                tail_index, tail_index_next;
  idx_t                cursor_index, cursor_index_next;
  logic [CAPACITY-1:0] free_map, free_map_next;
  idx_t                entry_count, entry_count_next;

  logic                accept;
  cmd_t                command;
  logic [VALUE_W-1:0]  value_in;

  idx_t                nx_c, pv_c, nx_h, pv_t, nx_d, pv_d;
  logic [ADDR_W-1:0]   free_addr;
  logic                pool_full;

  logic                val_we;
  logic [ADDR_W-1:0]   val_waddr;
  logic [VALUE_W-1:0]  val_wdata;
  link_wr_t            nxt_wa, nxt_wb, prv_wa, prv_wb;

  logic [VALUE_W-1:0]  rv;
  logic                rvalid, err;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = !m_tvalid || m_tready;
  assign command  = cmd_t'(s_tdata[CMD_W-1:0]);
  assign value_in = s_tdata[CMD_W +: VALUE_W];

  // link lookups; only used where the index is known to be a live node
  assign nx_c = next_link[cursor_index[ADDR_W-1:0]];
  assign pv_c = prev_link[cursor_index[ADDR_W-1:0]];
  assign nx_h = next_link[head_index[ADDR_W-1:0]];
  assign pv_t = prev_link[tail_index[ADDR_W-1:0]];
  assign nx_d = next_link[nx_c[ADDR_W-1:0]];
  assign pv_d = prev_link[pv_c[ADDR_W-1:0]];

  assign pool_full = (free_map == '0);

  // lowest free node wins
  always_comb begin
    free_addr = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free_map[i]) free_addr = ADDR_W'(i);
    end
  end

  always_comb begin
    head_index_next   = head_index;
    tail_index_next   = tail_index;
    cursor_index_next = cursor_index;
    free_map_next     = free_map;
    entry_count_next  = entry_count;
    val_we            = 1'b0;
    val_waddr         = free_addr;
    val_wdata         = value_in;
    nxt_wa            = '{en: 1'b0, addr: free_addr, data: NIL};
    nxt_wb            = '{en: 1'b0, addr: free_addr, data: NIL};
    prv_wa            = '{en: 1'b0, addr: free_addr, data: NIL};
    prv_wb            = '{en: 1'b0, addr: free_addr, data: NIL};
    rv                = '0;
    rvalid            = 1'b0;
    err               = 1'b0;

    unique case (command)
      CMD_CLEAR: begin
        head_index_next   = NIL;
        tail_index_next   = NIL;
        cursor_index_next = NIL;
        free_map_next     = '1;
        entry_count_next  = '0;
      end
      CMD_INS_FIRST: begin
        if (pool_full) begin
          err = 1'b1;
        end else begin
          free_map_next[free_addr] = 1'b0;
          entry_count_next = entry_count + 1'b1;
          val_we = 1'b1;
          nxt_wa = '{en: 1'b1, addr: free_addr, data: head_index};
          prv_wa = '{en: 1'b1, addr: free_addr, data: NIL};
          if (head_index != NIL) begin
            prv_wb = '{en: 1'b1, addr: head_index[ADDR_W-1:0], data: IDX_W'(free_addr)};
          end else begin
            tail_index_next = IDX_W'(free_addr);
          end
          head_index_next = IDX_W'(free_addr);
        end
      end
      CMD_INS_LAST: begin
        if (pool_full) begin
          err = 1'b1;
        end else begin
          free_map_next[free_addr] = 1'b0;
          entry_count_next = entry_count + 1'b1;
          val_we = 1'b1;
          nxt_wa = '{en: 1'b1, addr: free_addr, data: NIL};
          prv_wa = '{en: 1'b1, addr: free_addr, data: tail_index};
          if (tail_index != NIL) begin
            nxt_wb = '{en: 1'b1, addr: tail_index[ADDR_W-1:0], data: IDX_W'(free_addr)};
          end else begin
            head_index_next = IDX_W'(free_addr);
          end
          tail_index_next = IDX_W'(free_addr);
        end
      end
      CMD_FIRST: cursor_index_next = head_index;
      CMD_LAST:  cursor_index_next = tail_index;
      CMD_GET_FIRST, CMD_GET_LAST: begin
        if (head_index == NIL) begin
          err = 1'b1;
        end else begin
          rvalid = 1'b1;
          rv = (command == CMD_GET_FIRST) ? value_store[head_index[ADDR_W-1:0]]
                                          : value_store[tail_index[ADDR_W-1:0]];
        end
      end
      CMD_DEL_FIRST: begin
        if (head_index != NIL) begin
          if (cursor_index == head_index) cursor_index_next = NIL;
          if (head_index == tail_index) begin
            head_index_next = NIL;
            tail_index_next = NIL;
          end else begin
            head_index_next = nx_h;
            prv_wa = '{en: 1'b1, addr: nx_h[ADDR_W-1:0], data: NIL};
          end
          free_map_next[head_index[ADDR_W-1:0]] = 1'b1;
          entry_count_next = entry_count - 1'b1;
        end
      end
      CMD_DEL_LAST: begin
        if (head_index != NIL) begin
          if (cursor_index == tail_index) cursor_index_next = NIL;
          if (head_index == tail_index) begin
            head_index_next = NIL;
            tail_index_next = NIL;
          end else begin
            tail_index_next = pv_t;
            nxt_wa = '{en: 1'b1, addr: pv_t[ADDR_W-1:0], data: NIL};
          end
          free_map_next[tail_index[ADDR_W-1:0]] = 1'b1;
          entry_count_next = entry_count - 1'b1;
        end
      end
      CMD_DEL_AFTER: begin
        // removed node is nx_c
        if (cursor_index != NIL && cursor_index != tail_index) begin
          nxt_wa = '{en: 1'b1, addr: cursor_index[ADDR_W-1:0], data: nx_d};
          if (tail_index == nx_c) begin
            tail_index_next = cursor_index;
          end else begin
            prv_wa = '{en: 1'b1, addr: nx_d[ADDR_W-1:0], data: cursor_index};
          end
          free_map_next[nx_c[ADDR_W-1:0]] = 1'b1;
          entry_count_next = entry_count - 1'b1;
        end
      end
      CMD_DEL_BEFORE: begin
        // removed node is pv_c
        if (cursor_index != NIL && cursor_index != head_index) begin
          prv_wa = '{en: 1'b1, addr: cursor_index[ADDR_W-1:0], data: pv_d};
          if (head_index == pv_c) begin
            head_index_next = cursor_index;
          end else begin
            nxt_wa = '{en: 1'b1, addr: pv_d[ADDR_W-1:0], data: cursor_index};
          end
          free_map_next[pv_c[ADDR_W-1:0]] = 1'b1;
          entry_count_next = entry_count - 1'b1;
        end
      end
      CMD_INS_AFTER: begin
        if (cursor_index != NIL) begin
          if (pool_full) begin
            err = 1'b1;
          end else begin
            free_map_next[free_addr] = 1'b0;
            entry_count_next = entry_count + 1'b1;
            val_we = 1'b1;
            prv_wa = '{en: 1'b1, addr: free_addr, data: cursor_index};
            nxt_wa = '{en: 1'b1, addr: free_addr, data: nx_c};
            nxt_wb = '{en: 1'b1, addr: cursor_index[ADDR_W-1:0], data: IDX_W'(free_addr)};
            if (cursor_index == tail_index) begin
              tail_index_next = IDX_W'(free_addr);
            end else begin
              prv_wb = '{en: 1'b1, addr: nx_c[ADDR_W-1:0], data: IDX_W'(free_addr)};
            end
          end
        end
      end
      CMD_INS_BEFORE: begin
        if (cursor_index != NIL) begin
          if (pool_full) begin
            err = 1'b1;
          end else begin
            free_map_next[free_addr] = 1'b0;
            entry_count_next = entry_count + 1'b1;
            val_we = 1'b1;
            nxt_wa = '{en: 1'b1, addr: free_addr, data: cursor_index};
            prv_wa = '{en: 1'b1, addr: free_addr, data: pv_c};
            prv_wb = '{en: 1'b1, addr: cursor_index[ADDR_W-1:0], data: IDX_W'(free_addr)};
            if (cursor_index == head_index) begin
              head_index_next = IDX_W'(free_addr);
            end else begin
              nxt_wb = '{en: 1'b1, addr: pv_c[ADDR_W-1:0], data: IDX_W'(free_addr)};
            end
          end
        end
      end
      CMD_GET: begin
        if (cursor_index == NIL) begin
          err = 1'b1;
        end else begin
          rvalid = 1'b1;
          rv = value_store[cursor_index[ADDR_W-1:0]];
        end
      end
      CMD_SET: begin
        if (cursor_index != NIL) begin
          val_we    = 1'b1;
          val_waddr = cursor_index[ADDR_W-1:0];
        end
      end
      CMD_NEXT: begin
        if (cursor_index != NIL) begin
          cursor_index_next = (cursor_index == tail_index) ? NIL : nx_c;
        end
      end
      CMD_PREV: begin
        if (cursor_index != NIL) begin
          cursor_index_next = (cursor_index == head_index) ? NIL : pv_c;
        end
      end
      default: begin
      end
    endcase
  end

  // node pool, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      if (val_we) value_store[val_waddr] <= val_wdata;
      if (nxt_wa.en) next_link[nxt_wa.addr] <= nxt_wa.data;
      if (nxt_wb.en) next_link[nxt_wb.addr] <= nxt_wb.data;
      if (prv_wa.en) prev_link[prv_wa.addr] <= prv_wa.data;
      if (prv_wb.en) prev_link[prv_wb.addr] <= prv_wb.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_index   <= NIL;
      tail_index   <= NIL;
      cursor_index <= NIL;
      free_map     <= '1;
      entry_count  <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (accept) begin
        head_index   <= head_index_next;
        tail_index   <= tail_index_next;
        cursor_index <= cursor_index_next;
        free_map     <= free_map_next;
        entry_count  <= entry_count_next;
        m_tvalid     <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {COUNT_W'(entry_count_next), (cursor_index_next != NIL), err, rvalid, rv};
    end
  end

  a_count_matches_free_map: assert property (@(posedge clk) disable iff (rst)
    $countones(free_map) == CAPACITY - int'(entry_count))
    else $error("entry count disagrees with free map");

  a_ends_null_together: assert property (@(posedge clk) disable iff (rst)
    (head_index == NIL) == (tail_index == NIL))
    else $error("head and tail disagree on empty list");

  a_cursor_needs_list: assert property (@(posedge clk) disable iff (rst)
    head_index == NIL |-> cursor_index == NIL)
    else $error("cursor active on empty list");

  a_result_follows_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted item produced no result");

endmodule

>>> tb/tb_doubly_linked_list_with_cursor_top.sv
`timescale 1ns / 100ps

module tb_doubly_linked_list_with_cursor_top;
  import dllc_pkg::*;

  localparam int RANDOM_CMDS  = 1125;
  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_START   = 600;
  localparam int HOLD_LEN     = 300;
  localparam int PHASE_LEN    = 80;
  localparam int MAX_REPORTS  = 10;
  localparam int DIR_N        = 25;

  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 5'd17;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 5'd31;

  // packed so that a cast of m_tdata lines up with the port layout
  typedef struct packed {
    logic [COUNT_W-1:0] entries;
    logic               cursor_on;
    logic               err;
    logic               rd_valid;
    logic [VALUE_W-1:0] rd_value;
  } list_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]   code;
    logic [VALUE_W-1:0] value;
    logic               typed;
    list_result_t       want;
  } list_step_t;

  localparam list_result_t RES_QUIET =
    '{entries: 5'd0, cursor_on: 1'b0, err: 1'b0, rd_valid: 1'b0, rd_value: 32'd0};
  localparam list_result_t RES_EMPTY_READ =
    '{entries: 5'd0, cursor_on: 1'b0, err: 1'b1, rd_valid: 1'b0, rd_value: 32'd0};

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;

  // shadow copy of the node pool
  logic [VALUE_W-1:0]  node_val  [CAPACITY];
  idx_t                node_next [CAPACITY];
  idx_t                node_prev [CAPACITY];
  idx_t                head_idx, tail_idx, cur_idx;
  logic [CAPACITY-1:0] free_nodes;
  logic [COUNT_W-1:0]  live_count;

  list_result_t expected_results[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           burst_left = 0;

  cmd_t cmd_groups [4][4] = '{
    '{CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_AFTER, CMD_INS_BEFORE},
    '{CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_AFTER, CMD_DEL_BEFORE},
    '{CMD_FIRST, CMD_LAST, CMD_NEXT, CMD_PREV},
    '{CMD_GET_FIRST, CMD_GET_LAST, CMD_GET, CMD_SET}
  };

  doubly_linked_list_with_cursor_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // node address of a live index
  function automatic logic [ADDR_W-1:0] slot(input idx_t i);
    return i[ADDR_W-1:0];
  endfunction

  // lowest free node wins
  function automatic idx_t grab_node(input logic [VALUE_W-1:0] v);
    idx_t n;
    n = NIL;
    for (int i = CAPACITY - 1; i >= 0; i--)
      if (free_nodes[i]) n = idx_t'(i);
    if (n != NIL) begin
      free_nodes[slot(n)] = 1'b0;
      node_val[slot(n)] = v;
      live_count++;
    end
    return n;
  endfunction

  function automatic void release_node(input idx_t d);
    free_nodes[slot(d)] = 1'b1;
    if (live_count != 0) live_count--;
  endfunction

  function automatic void empty_list();
    free_nodes = '1;
    head_idx = NIL;
    tail_idx = NIL;
    cur_idx = NIL;
    live_count = '0;
  endfunction

  function automatic list_result_t apply_list_cmd(input logic [CMD_W-1:0] code,
                                                  input logic [VALUE_W-1:0] v);
    list_result_t r;
    idx_t n, d;
    r = '0;
    case (code)
      CMD_CLEAR: empty_list();
      CMD_INS_FIRST: begin
        n = grab_node(v);
        if (n == NIL) r.err = 1'b1;
        else begin
          node_prev[slot(n)] = NIL;
          node_next[slot(n)] = head_idx;
          if (head_idx != NIL) node_prev[slot(head_idx)] = n;
          else tail_idx = n;
          head_idx = n;
        end
      end
      CMD_INS_LAST: begin
        n = grab_node(v);
        if (n == NIL) r.err = 1'b1;
        else begin
          node_next[slot(n)] = NIL;
          node_prev[slot(n)] = tail_idx;
          if (tail_idx != NIL) node_next[slot(tail_idx)] = n;
          else head_idx = n;
          tail_idx = n;
        end
      end
      CMD_FIRST: cur_idx = head_idx;
      CMD_LAST:  cur_idx = tail_idx;
      CMD_GET_FIRST, CMD_GET_LAST: begin
        if (head_idx == NIL) r.err = 1'b1;
        else begin
          r.rd_value = node_val[slot((code == CMD_GET_FIRST) ? head_idx : tail_idx)];
          r.rd_valid = 1'b1;
        end
      end
      CMD_DEL_FIRST: begin
        if (head_idx != NIL) begin
          d = head_idx;
          if (cur_idx == d) cur_idx = NIL;
          if (head_idx == tail_idx) begin
            head_idx = NIL;
            tail_idx = NIL;
          end else begin
            head_idx = node_next[slot(d)];
            node_prev[slot(head_idx)] = NIL;
          end
          release_node(d);
        end
      end
      CMD_DEL_LAST: begin
        if (head_idx != NIL) begin
          d = tail_idx;
          if (cur_idx == d) cur_idx = NIL;
          if (head_idx == tail_idx) begin
            head_idx = NIL;
            tail_idx = NIL;
          end else begin
            tail_idx = node_prev[slot(d)];
            node_next[slot(tail_idx)] = NIL;
          end
          release_node(d);
        end
      end
      CMD_DEL_AFTER: begin
        if (cur_idx != NIL && cur_idx != tail_idx) begin
          d = node_next[slot(cur_idx)];
          node_next[slot(cur_idx)] = node_next[slot(d)];
          if (tail_idx == d) tail_idx = cur_idx;
          else node_prev[slot(node_next[slot(d)])] = cur_idx;
          release_node(d);
        end
      end
      CMD_DEL_BEFORE: begin
        if (cur_idx != NIL && cur_idx != head_idx) begin
          d = node_prev[slot(cur_idx)];
          node_prev[slot(cur_idx)] = node_prev[slot(d)];
          if (head_idx == d) head_idx = cur_idx;
          else node_next[slot(node_prev[slot(d)])] = cur_idx;
          release_node(d);
        end
      end
      CMD_INS_AFTER: begin
        if (cur_idx != NIL) begin
          n = grab_node(v);
          if (n == NIL) r.err = 1'b1;
          else begin
            node_prev[slot(n)] = cur_idx;
            node_next[slot(n)] = node_next[slot(cur_idx)];
            node_next[slot(cur_idx)] = n;
            if (cur_idx == tail_idx) tail_idx = n;
            else node_prev[slot(node_next[slot(n)])] = n;
          end
        end
      end
      CMD_INS_BEFORE: begin
        if (cur_idx != NIL) begin
          n = grab_node(v);
          if (n == NIL) r.err = 1'b1;
          else begin
            node_next[slot(n)] = cur_idx;
            node_prev[slot(n)] = node_prev[slot(cur_idx)];
            node_prev[slot(cur_idx)] = n;
            if (cur_idx == head_idx) head_idx = n;
            else node_next[slot(node_prev[slot(n)])] = n;
          end
        end
      end
      CMD_GET: begin
        if (cur_idx == NIL) r.err = 1'b1;
        else begin
          r.rd_value = node_val[slot(cur_idx)];
          r.rd_valid = 1'b1;
        end
      end
      CMD_SET: if (cur_idx != NIL) node_val[slot(cur_idx)] = v;
      // stepping off either end drops the cursor
      CMD_NEXT:
        if (cur_idx != NIL) cur_idx = (cur_idx == tail_idx) ? NIL : node_next[slot(cur_idx)];
      CMD_PREV:
        if (cur_idx != NIL) cur_idx = (cur_idx == head_idx) ? NIL : node_prev[slot(cur_idx)];
      default: ;
    endcase
    r.cursor_on = (cur_idx != NIL);
    r.entries = live_count;
    return r;
  endfunction

  // offers one command item in bursts with random gaps, predicts on acceptance
  task automatic offer(input logic [CMD_W-1:0] code, input logic [VALUE_W-1:0] v,
                       output list_result_t predicted);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= IN_W'({v, code});
    do @(posedge clk); while (!s_tready);
    predicted = apply_list_cmd(code, v);
  endtask

  initial begin : drive
    list_step_t         steps [DIR_N];
    list_result_t       predicted;
    logic [CMD_W-1:0]   code;
    logic [VALUE_W-1:0] v;
    int                 random_cmds, phase_left, mix, r, grp;
    int                 ins_lim, del_lim, move_lim;

    steps = '{
      '{CMD_GET_FIRST,  32'd0,          1'b1, RES_EMPTY_READ},
      '{CMD_GET,        32'd0,          1'b1, RES_EMPTY_READ},
      '{CMD_DEL_LAST,   32'd0,          1'b1, RES_QUIET},
      '{CMD_FIRST,      32'd0,          1'b1, RES_QUIET},
      '{CMD_INS_LAST,   32'h7fff_ffff,  1'b1,
        '{entries: 5'd1, cursor_on: 1'b0, err: 1'b0, rd_valid: 1'b0, rd_value: 32'd0}},
      '{CMD_INS_FIRST,  32'h8000_0000,  1'b1,
        '{entries: 5'd2, cursor_on: 1'b0, err: 1'b0, rd_valid: 1'b0, rd_value: 32'd0}},
      '{CMD_GET_FIRST,  32'd0,          1'b1,
        '{entries: 5'd2, cursor_on: 1'b0, err: 1'b0, rd_valid: 1'b1,
          rd_value: 32'h8000_0000}},
      '{CMD_GET_LAST,   32'd0,          1'b1,
        '{entries: 5'd2, cursor_on: 1'b0, err: 1'b0, rd_valid: 1'b1,
          rd_value: 32'h7fff_ffff}},
      '{CMD_FIRST,      32'd0,          1'b0, RES_QUIET},
      '{CMD_NEXT,       32'd0,          1'b0, RES_QUIET},
      '{CMD_NEXT,       32'd0,          1'b0, RES_QUIET},
      '{CMD_LAST,       32'd0,          1'b0, RES_QUIET},
      '{CMD_INS_BEFORE, 32'hffff_ffff,  1'b0, RES_QUIET},
      '{CMD_INS_AFTER,  32'd0,          1'b0, RES_QUIET},
      '{CMD_PREV,       32'd0,          1'b0, RES_QUIET},
      '{CMD_DEL_AFTER,  32'd0,          1'b0, RES_QUIET},
      '{CMD_DEL_BEFORE, 32'd0,          1'b0, RES_QUIET},
      '{CMD_DEL_BEFORE, 32'd0,          1'b0, RES_QUIET},
      '{CMD_SET,        32'h5555_aaaa,  1'b0, RES_QUIET},
      '{CMD_GET,        32'd0,          1'b0, RES_QUIET},
      '{CMD_DEL_FIRST,  32'd0,          1'b0, RES_QUIET},
      '{CMD_SET,        32'haaaa_5555,  1'b0, RES_QUIET},
      '{CMD_UNUSED_HI,  32'hffff_ffff,  1'b0, RES_QUIET},
      '{CMD_CLEAR,      32'd0,          1'b1, RES_QUIET},
      '{CMD_INS_AFTER,  32'h1234_5678,  1'b1, RES_QUIET}
    };

    for (int i = 0; i < CAPACITY; i++) begin
      node_val[i] = '0;
      node_next[i] = NIL;
      node_prev[i] = NIL;
    end
    empty_list();

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      offer(steps[i].code, steps[i].value, predicted);
      expected_results.push_back(steps[i].typed ? steps[i].want : predicted);
    end

    // phases lean toward growing, shrinking or walking the cursor
    random_cmds = 0;
    phase_left = 0;
    mix = 0;
    while (random_cmds < RANDOM_CMDS) begin
      if (phase_left == 0) begin
        phase_left = PHASE_LEN;
        mix = $urandom_range(0, 2);
      end
      phase_left--;
      case (mix)
        0:       begin ins_lim = 50; del_lim = 60; move_lim = 80; end
        1:       begin ins_lim = 10; del_lim = 60; move_lim = 80; end
        default: begin ins_lim = 15; del_lim = 30; move_lim = 70; end
      endcase
      r = $urandom_range(0, 99);
      if (r < 3) code = CMD_UNUSED_LO + CMD_W'($urandom_range(0, CMD_UNUSED_HI - CMD_UNUSED_LO));
      else if (r < 4) code = CMD_CLEAR;
      else begin
        r = $urandom_range(0, 99);
        grp = (r < ins_lim) ? 0 : (r < del_lim) ? 1 : (r < move_lim) ? 2 : 3;
        code = cmd_groups[grp][$urandom_range(0, 3)];
      end
      case ($urandom_range(0, 11))
        0:       v = 32'h8000_0000;
        1:       v = 32'h7fff_ffff;
        2:       v = 32'h0000_0000;
        3:       v = 32'hffff_ffff;
        default: v = $urandom;
      endcase
      offer(code, v, predicted);
      expected_results.push_back(predicted);
      random_cmds++;
    end
    s_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("doubly_linked_list_with_cursor_top verification clean");
    else
      $display("doubly_linked_list_with_cursor_top verification failed");
    $finish;
  end

  // receiver: rotating stall windows plus one long hold-off to back up the input
  initial begin : sink
    int rx_cyc;
    rx_cyc = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      rx_cyc++;
      if (rx_cyc >= HOLD_START && rx_cyc < HOLD_START + HOLD_LEN)
        m_tready <= 1'b0;
      else begin
        case ((rx_cyc / 64) % 4)
          0:       m_tready <= 1'b1;
          1:       m_tready <= ($urandom_range(0, 9) < 7);
          2:       m_tready <= (rx_cyc % 3 != 0);
          default: m_tready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    list_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = list_result_t'(m_tdata);
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result item: m_tdata=%h", m_tdata);
      end else begin
        want = expected_results.pop_front();
        if (got.rd_value !== want.rd_value || got.rd_valid !== want.rd_valid ||
            got.err !== want.err || got.cursor_on !== want.cursor_on ||
            got.entries !== want.entries) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("result mismatch: exp value=%h valid=%b err=%b cursor=%b count=%0d",
                     want.rd_value, want.rd_valid, want.err, want.cursor_on, want.entries,
                     " / got value=%h valid=%b err=%b cursor=%b count=%0d",
                     got.rd_value, got.rd_valid, got.err, got.cursor_on, got.entries);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("doubly_linked_list_with_cursor_top verification failed");
      $finish;
    end
  end

endmodule
